@@ hw/rtl/aqs_pkg.sv @@
// Package with the types, codes and constants of the air quality classifier.
package aqs_pkg;

    localparam int AQS_ADC_BITS = 12;
    localparam int ADC_FIELD_W  = 12;
    localparam int ADC_EXT_W    = 16;
    localparam int SUM_W        = 32;
    localparam int CNT_W        = 16;
    localparam int BASE_W       = 17;
    localparam int PT_W         = 17;
    localparam int ST_W         = 16;
    localparam int WT_W         = 20;
    localparam int LIM_W        = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;

    localparam int CHECK_HIGH     = 798;
    localparam int CHECK_LOW      = 10;
    localparam int LVL_DIFF_HIGH  = 400;
    localparam int LVL_ABS_HIGH   = 700;
    localparam int LVL_BASE_HIGH  = 150;
    localparam int LVL_DIFF_LOW   = 200;
    localparam int LVL_BASE_LOW   = 50;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_ABORT   = 2'd2;

    localparam logic [1:0] LVL_FORCED = 2'd0;
    localparam logic [1:0] LVL_HIGH   = 2'd1;
    localparam logic [1:0] LVL_LOW    = 2'd2;
    localparam logic [1:0] LVL_FRESH  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd5;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_WARM  = 3'd1,
        PH_CHECK = 3'd2,
        PH_RETRY = 3'd3,
        PH_READY = 3'd4,
        PH_ERROR = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_EXEC = 2'd1,
        SEQ_DIV  = 2'd2,
        SEQ_PUSH = 2'd3
    } seq_t;

    typedef struct packed {
        logic [1:0]             action;
        logic [ADC_FIELD_W-1:0] adc_reading;
    } tick_t;

    typedef struct packed {
        logic       ready_res;
        logic       error;
        logic       level_valid;
        logic [1:0] pollution_level;
        logic [2:0] phase;
        logic       new_sample;
    } result_t;

endpackage

@@ hw/rtl/aqs_div.sv @@
// Bit-serial restoring divider that forms the baseline mean, one quotient bit per cycle.
module aqs_div
    import aqs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [BASE_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[BASE_W-1:0];

endmodule

@@ hw/rtl/aqs_class.sv @@
// Pollution level decision from the absolute reading and its rise over the previous sample and the baseline.
module aqs_class
    import aqs_pkg::*;
#(
    parameter int ADC_BITS = AQS_ADC_BITS
)
(
    input  logic [ADC_BITS-1:0] sample,
    input  logic [ADC_BITS-1:0] previous,
    input  logic [BASE_W-1:0]   baseline,
    output logic [1:0]          level
);

    logic signed [ADC_BITS:0] rise_prev;
    logic signed [BASE_W+1:0] rise_base;

    always_comb
    begin
        rise_prev = signed'({1'b0, sample} - {1'b0, previous});
        rise_base = signed'({{(BASE_W + 2 - ADC_BITS){1'b0}}, sample}
                            - {2'b00, baseline});
        priority if (rise_prev > LVL_DIFF_HIGH || sample > LVL_ABS_HIGH)
        begin
            level = LVL_FORCED;
        end
        else if (rise_base > LVL_BASE_HIGH)
        begin
            level = LVL_HIGH;
        end
        else if ((rise_prev > LVL_DIFF_LOW && sample < LVL_ABS_HIGH)
                 || rise_base > LVL_BASE_LOW)
        begin
            level = LVL_LOW;
        end
        else
        begin
            level = LVL_FRESH;
        end
    end

endmodule

@@ hw/rtl/air_quality_sensor_classifier.sv @@
// Top level of the gas sensor air quality classifier: sequencer, state and result register.
//
// Each input item on the tick channel is a one-millisecond tick carrying the
// converter reading, a restart or an abort. Every item gives exactly one result
// item on the result channel: ready and error flags, the current pollution level
// with its valid flag, the phase and a flag for a fresh sample.
// An item is taken when tick_valid and tick_ready are high at a clock edge; the
// block then handles it alone and takes no new item until its result is stored.
// A plain tick or command passes through the execute and push states, and its
// result enters the output register as the block turns ready again. A tick that
// closes an averaging window also waits in the divide state for the 32-step
// bit-serial divider that forms the baseline mean. The output register holds one
// result; while it is full and not taken, the finished result waits in the
// sequencer and no new item is accepted. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while idle, as the block
// does not enforce it. After reset the block is in the error phase with default
// register values and stays there until a restart item arrives.
module air_quality_sensor_classifier
    import aqs_pkg::*;
#(
    parameter int ADC_BITS = AQS_ADC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_ready,
    input  tick_t                 tick,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    seq_t seq_reg, seq_next;

    logic [15:0]      start_delay_reg;
    logic [PT_W-1:0]  warmup_reg;
    logic [PT_W-1:0]  retry_wait_reg;
    logic [ST_W-1:0]  interval_reg;
    logic [WT_W-1:0]  window_reg;
    logic [LIM_W-1:0] retry_limit_reg;

    logic [1:0]          action_reg;
    logic [ADC_BITS-1:0] rd_reg;
    logic [ADC_EXT_W-1:0] rd_ext;

    phase_t              phase_reg, phase_next;
    logic [PT_W-1:0]     phase_timer_reg, phase_timer_next;
    logic [LIM_W-1:0]    retry_count_reg, retry_count_next;
    logic [ADC_BITS-1:0] check_voltage_reg, check_voltage_next;
    logic [ST_W-1:0]     sample_timer_reg, sample_timer_next;
    logic [WT_W-1:0]     window_timer_reg, window_timer_next;
    logic [ADC_BITS-1:0] previous_reg, previous_next;
    logic [BASE_W-1:0]   baseline_reg, baseline_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                level_valid_reg, level_valid_next;
    logic [1:0]          level_reg, level_next;
    logic                error_reg, error_next;
    logic                fresh_reg, fresh_next;

    logic                result_valid_reg;
    result_t             result_reg;

    logic                exec_en;
    logic                push_en;
    logic                slot_free;

    logic [PT_W-1:0]     pt_inc;
    logic [PT_W-1:0]     pt_limit;
    logic [ST_W-1:0]     st_inc;
    logic [WT_W-1:0]     wt_inc;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W-1:0]    count_inc;
    logic [1:0]          class_level;
    logic                div_start;
    logic                div_done;
    logic [BASE_W-1:0]   div_quotient;

    aqs_class #(
        .ADC_BITS (ADC_BITS)
    ) u_class (
        .sample   (rd_reg),
        .previous (previous_reg),
        .baseline (baseline_reg),
        .level    (class_level)
    );

    aqs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_add),
        .divisor  (count_inc),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign slot_free = !result_valid_reg || result_ready;
    assign rd_ext    = {{(ADC_EXT_W - ADC_FIELD_W){1'b0}}, tick.adc_reading};

    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_IDLE: if (tick_valid) seq_next = SEQ_EXEC;
            SEQ_EXEC: seq_next = div_start ? SEQ_DIV : SEQ_PUSH;
            SEQ_DIV:  if (div_done) seq_next = SEQ_PUSH;
            SEQ_PUSH: if (slot_free) seq_next = SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        tick_ready = (seq_reg == SEQ_IDLE);
        exec_en    = (seq_reg == SEQ_EXEC);
        push_en    = (seq_reg == SEQ_PUSH) && slot_free;
    end

    always_comb
    begin
        pt_inc    = (phase_timer_reg == '1) ? phase_timer_reg : phase_timer_reg + 1'b1;
        pt_limit  = (phase_reg == PH_WARM) ? warmup_reg : retry_wait_reg;
        st_inc    = (sample_timer_reg == '1) ? sample_timer_reg : sample_timer_reg + 1'b1;
        wt_inc    = (window_timer_reg == '1) ? window_timer_reg : window_timer_reg + 1'b1;
        sum_wide  = {1'b0, sum_reg} + {{(SUM_W + 1 - ADC_BITS){1'b0}}, rd_reg};
        sum_add   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    end

    always_comb
    begin
        phase_next         = phase_reg;
        phase_timer_next   = phase_timer_reg;
        retry_count_next   = retry_count_reg;
        check_voltage_next = check_voltage_reg;
        sample_timer_next  = sample_timer_reg;
        window_timer_next  = window_timer_reg;
        previous_next      = previous_reg;
        baseline_next      = baseline_reg;
        sum_next           = sum_reg;
        count_next         = count_reg;
        level_valid_next   = level_valid_reg;
        level_next         = level_reg;
        error_next         = error_reg;
        fresh_next         = fresh_reg;
        div_start          = 1'b0;
        if (exec_en)
        begin
            fresh_next = 1'b0;
            unique case (action_reg)
                ACT_TICK:
                begin
                    unique case (phase_reg)
                        PH_WAIT:
                        begin
                            phase_timer_next = pt_inc;
                            if (pt_inc >= {1'b0, start_delay_reg})
                            begin
                                phase_timer_next = '0;
                                phase_next       = PH_WARM;
                            end
                        end
                        PH_WARM, PH_RETRY:
                        begin
                            phase_timer_next = pt_inc;
                            if (pt_inc >= pt_limit)
                            begin
                                check_voltage_next = rd_reg;
                                phase_next         = PH_CHECK;
                            end
                        end
                        PH_CHECK:
                        begin
                            if (check_voltage_reg < CHECK_HIGH && check_voltage_reg > CHECK_LOW)
                            begin
                                previous_next     = rd_reg;
                                baseline_next     = {{(BASE_W - ADC_BITS){1'b0}}, rd_reg};
                                error_next        = 1'b0;
                                window_timer_next = '0;
                                sum_next          = '0;
                                count_next        = '0;
                                sample_timer_next = '0;
                                phase_next        = PH_READY;
                            end
                            else
                            begin
                                retry_count_next = retry_count_reg + 1'b1;
                                phase_timer_next = '0;
                                phase_next       = PH_RETRY;
                                if (retry_count_next >= retry_limit_reg)
                                begin
                                    error_next = 1'b1;
                                    phase_next = PH_ERROR;
                                end
                            end
                        end
                        PH_READY:
                        begin
                            sample_timer_next = st_inc;
                            window_timer_next = wt_inc;
                            if (st_inc >= interval_reg)
                            begin
                                sample_timer_next = '0;
                                level_next        = class_level;
                                level_valid_next  = 1'b1;
                                sum_next          = sum_add;
                                count_next        = count_inc;
                                previous_next     = rd_reg;
                                fresh_next        = 1'b1;
                                if (wt_inc >= window_reg)
                                begin
                                    div_start         = 1'b1;
                                    sum_next          = '0;
                                    count_next        = '0;
                                    window_timer_next = '0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ACT_RESTART:
                begin
                    if (phase_reg != PH_READY)
                    begin
                        phase_next       = PH_WAIT;
                        phase_timer_next = '0;
                        retry_count_next = '0;
                        error_next       = 1'b0;
                        level_valid_next = 1'b0;
                        level_next       = LVL_FORCED;
                    end
                end
                ACT_ABORT:
                begin
                    phase_next = PH_ERROR;
                end
                default:
                begin
                end
            endcase
        end
        else if (seq_reg == SEQ_DIV && div_done)
        begin
            baseline_next = div_quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg           <= SEQ_IDLE;
            start_delay_reg   <= 16'd3000;
            warmup_reg        <= 17'd20000;
            retry_wait_reg    <= 17'd60000;
            interval_reg      <= 16'd2000;
            window_reg        <= 20'd300000;
            retry_limit_reg   <= 4'd5;
            phase_reg         <= PH_ERROR;
            phase_timer_reg   <= '0;
            retry_count_reg   <= '0;
            check_voltage_reg <= '0;
            sample_timer_reg  <= '0;
            window_timer_reg  <= '0;
            previous_reg      <= '0;
            baseline_reg      <= '0;
            sum_reg           <= '0;
            count_reg         <= '0;
            level_valid_reg   <= 1'b0;
            level_reg         <= LVL_FORCED;
            error_reg         <= 1'b0;
            fresh_reg         <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            seq_reg           <= seq_next;
            phase_reg         <= phase_next;
            phase_timer_reg   <= phase_timer_next;
            retry_count_reg   <= retry_count_next;
            check_voltage_reg <= check_voltage_next;
            sample_timer_reg  <= sample_timer_next;
            window_timer_reg  <= window_timer_next;
            previous_reg      <= previous_next;
            baseline_reg      <= baseline_next;
            sum_reg           <= sum_next;
            count_reg         <= count_next;
            level_valid_reg   <= level_valid_next;
            level_reg         <= level_next;
            error_reg         <= error_next;
            fresh_reg         <= fresh_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_DELAY: start_delay_reg <= cfg_data[15:0];
                    CFG_WARMUP:      warmup_reg      <= cfg_data[PT_W-1:0];
                    CFG_RETRY_WAIT:  retry_wait_reg  <= cfg_data[PT_W-1:0];
                    CFG_INTERVAL:    interval_reg    <= cfg_data[ST_W-1:0];
                    CFG_WINDOW:      window_reg      <= cfg_data[WT_W-1:0];
                    CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[LIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (push_en)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            action_reg <= tick.action;
            rd_reg     <= rd_ext[ADC_BITS-1:0];
        end
        if (push_en)
        begin
            result_reg.ready_res       <= (phase_reg == PH_READY);
            result_reg.error           <= error_reg;
            result_reg.level_valid     <= level_valid_reg;
            result_reg.pollution_level <= level_valid_reg ? level_reg : LVL_FORCED;
            result_reg.phase           <= phase_reg;
            result_reg.new_sample      <= fresh_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Sampling only runs after a passed check, which clears the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_READY) |-> !error_reg)
        else $error("error flag set while sampling");

    // A window only closes while sampling, and nothing leaves the ready phase during a division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_DIV) |-> (phase_reg == PH_READY))
        else $error("division running outside the ready phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (seq_reg == SEQ_DIV))
        else $error("divider finished while the sequencer was not waiting for it");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> (seq_reg == SEQ_EXEC))
        else $error("accepted item was not executed in the next cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        !level_valid_reg |-> (level_reg == LVL_FORCED))
        else $error("level held without a classified sample");

endmodule
